[src/nrt_pkg.sv]
// Shared types and codes for the notification ring table.
// Used by nrt_ctrl, nrt_datapath and notification_ring_table; no dependencies.
`default_nettype none
package nrt_pkg;

    localparam logic [2:0] REQ_POST        = 3'd0;
    localparam logic [2:0] REQ_READ        = 3'd1;
    localparam logic [2:0] REQ_POP         = 3'd2;
    localparam logic [2:0] REQ_DISMISS     = 3'd3;
    localparam logic [2:0] REQ_DISMISS_ALL = 3'd4;

    localparam int IN_BITS  = 136;
    localparam int OUT_BITS = 224;

    typedef enum logic [1:0] {
        SRC_NONE = 2'd0,
        SRC_POST = 2'd1,
        SRC_MEM  = 2'd2
    } out_src_t;

    typedef struct packed {
        logic     in_ready;
        logic     post;
        logic     scan_init;
        logic     scan_step;
        logic     scan_read;
        logic     idx_clr;
        logic     idx_inc;
        logic     id_read;
        logic     dis_idx;
        logic     dis_all;
        logic     load_out;
        out_src_t out_src;
        logic     out_last;
    } nrt_cmd_t;

    typedef struct packed {
        logic [2:0] req_type;
        logic       target_zero;
        logic       scan_done;
        logic       scan_hit;
        logic       pending;
        logic       id_hit;
        logic       idx_end;
        logic       out_free;
    } nrt_sts_t;

endpackage
`default_nettype wire

[src/nrt_ctrl.sv]
// Request sequencer for the notification ring table.
// Depends on nrt_pkg; drives nrt_datapath through nrt_cmd_t.
`default_nettype none
module nrt_ctrl
    import nrt_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_accept,
    input  wire nrt_sts_t sts,
    output nrt_cmd_t      cmd
);

    typedef enum logic [8:0] {
        S_IDLE       = 9'b000000001,
        S_EXEC       = 9'b000000010,
        S_SCAN       = 9'b000000100,
        S_DREAD      = 9'b000001000,
        S_DCHK       = 9'b000010000,
        S_EMIT_NONE  = 9'b000100000,
        S_EMIT_POST  = 9'b001000000,
        S_EMIT_PEND  = 9'b010000000,
        S_EMIT_FINAL = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        cmd.out_src = SRC_NONE;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                cmd.in_ready = 1'b1;
                if (s_accept) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                case (sts.req_type)
                    REQ_POST: begin
                        cmd.post   = 1'b1;
                        state_next = S_EMIT_POST;
                    end
                    REQ_READ, REQ_POP: begin
                        cmd.scan_init = 1'b1;
                        state_next    = S_SCAN;
                    end
                    REQ_DISMISS: begin
                        if (sts.target_zero) begin
                            state_next = S_EMIT_NONE;
                        end else begin
                            cmd.idx_clr = 1'b1;
                            state_next  = S_DREAD;
                        end
                    end
                    REQ_DISMISS_ALL: begin
                        cmd.dis_all = 1'b1;
                        state_next  = S_EMIT_NONE;
                    end
                    default: begin
                        state_next = S_EMIT_NONE;
                    end
                endcase
            end
            S_SCAN: begin
                if (sts.scan_done) begin
                    state_next = sts.pending ? S_EMIT_FINAL : S_EMIT_NONE;
                end else if (sts.scan_hit && sts.pending) begin
                    state_next = S_EMIT_PEND;
                end else begin
                    cmd.scan_step = 1'b1;
                    cmd.scan_read = sts.scan_hit;
                end
            end
            S_DREAD: begin
                cmd.id_read = 1'b1;
                state_next  = S_DCHK;
            end
            S_DCHK: begin
                if (sts.id_hit) begin
                    cmd.dis_idx = 1'b1;
                    state_next  = S_EMIT_NONE;
                end else if (sts.idx_end) begin
                    state_next = S_EMIT_NONE;
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_DREAD;
                end
            end
            S_EMIT_NONE: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    cmd.out_src  = SRC_NONE;
                    cmd.out_last = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_EMIT_POST: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    cmd.out_src  = SRC_POST;
                    cmd.out_last = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_EMIT_PEND: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    cmd.out_src  = SRC_MEM;
                    state_next   = S_SCAN;
                end
            end
            S_EMIT_FINAL: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    cmd.out_src  = SRC_MEM;
                    cmd.out_last = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[src/nrt_datapath.sv]
// Slot storage, counters, scan pointers and output register of the ring table.
// Depends on nrt_pkg; steered by nrt_ctrl.
`default_nettype none
module nrt_datapath
    import nrt_pkg::*;
#(
    parameter int DEPTH       = 32,
    parameter int MAX_URGENCY = 2
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire nrt_cmd_t             cmd,
    output nrt_sts_t                  sts,
    input  wire logic                 s_accept,
    input  wire logic [IN_BITS-1:0]   s_data,
    input  wire logic                 m_tready,
    output logic                      m_tvalid,
    output logic [OUT_BITS-1:0]       m_data,
    output logic                      m_valid_flag,
    output logic                      m_last
);

    localparam int AW  = $clog2(DEPTH);
    localparam int RW  = $clog2(DEPTH + 1);
    localparam int CAP = (DEPTH < 32) ? DEPTH : 32;
    localparam logic [31:0]   DEPTH_W = 32'(DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [7:0]    MAX_URG = 8'(MAX_URGENCY);

    typedef struct packed {
        logic [31:0] id;
        logic [31:0] kind;
        logic [1:0]  urg;
        logic [47:0] tstamp;
    } rec_t;

    rec_t mem [DEPTH];
    rec_t mem_q_reg;

    logic [2:0]  req_reg;
    logic [31:0] kind_reg;
    logic [7:0]  urg_in_reg;
    logic [47:0] time_reg;
    logic [31:0] target_reg;
    logic [5:0]  limit_in_reg;

    logic [DEPTH-1:0] used_reg, disp_reg, dism_reg;
    logic [31:0] next_id_reg, write_head_reg, posted_reg, evicted_reg, dismissed_reg;
    logic [31:0] post_id_reg;
    logic [AW-1:0] head_slot_reg, scan_slot_reg, idx_reg;
    logic [RW-1:0] unread_reg, remain_reg;
    logic [5:0]  limit_reg, found_reg;
    logic        pend_reg, rec_disp_reg;

    logic [AW-1:0] prev_slot;
    logic [1:0]    urg_clamp;
    logic          is_pop;

    assign prev_slot = (scan_slot_reg == '0) ? LAST_SLOT : scan_slot_reg - 1'b1;
    assign urg_clamp = (urg_in_reg > MAX_URG) ? MAX_URG[1:0] : urg_in_reg[1:0];
    assign is_pop    = (req_reg == REQ_POP);

    always_comb begin
        sts.req_type    = req_reg;
        sts.target_zero = (target_reg == '0);
        sts.scan_done   = (remain_reg == '0) || (found_reg == limit_reg);
        sts.scan_hit    = used_reg[prev_slot] && !dism_reg[prev_slot]
                          && !(is_pop && disp_reg[prev_slot]);
        sts.pending     = pend_reg;
        sts.id_hit      = used_reg[idx_reg] && (mem_q_reg.id == target_reg);
        sts.idx_end     = (idx_reg == LAST_SLOT);
        sts.out_free    = !m_tvalid || m_tready;
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            req_reg      <= s_data[2:0];
            kind_reg     <= s_data[34:3];
            urg_in_reg   <= s_data[42:35];
            time_reg     <= s_data[90:43];
            target_reg   <= s_data[122:91];
            limit_in_reg <= s_data[128:123];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.post) begin
            mem[head_slot_reg] <= '{id: next_id_reg, kind: kind_reg,
                                    urg: urg_clamp, tstamp: time_reg};
        end
        if (cmd.scan_read) begin
            mem_q_reg <= mem[prev_slot];
        end else if (cmd.id_read) begin
            mem_q_reg <= mem[idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.post) begin
            post_id_reg <= next_id_reg;
        end
        if (cmd.scan_init) begin
            scan_slot_reg <= head_slot_reg;
            remain_reg    <= (write_head_reg >= DEPTH_W) ? RW'(DEPTH)
                                                         : write_head_reg[RW-1:0];
            limit_reg     <= is_pop ? 6'd1
                           : (limit_in_reg > 6'(CAP)) ? 6'(CAP) : limit_in_reg;
            found_reg     <= '0;
        end else if (cmd.scan_step) begin
            scan_slot_reg <= prev_slot;
            remain_reg    <= remain_reg - 1'b1;
            if (cmd.scan_read) begin
                found_reg    <= found_reg + 6'd1;
                rec_disp_reg <= disp_reg[prev_slot] | is_pop;
            end
        end
        if (cmd.idx_clr) begin
            idx_reg <= '0;
        end else if (cmd.idx_inc) begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg       <= '0;
            next_id_reg    <= 32'd1;
            write_head_reg <= '0;
            head_slot_reg  <= '0;
            posted_reg     <= '0;
            evicted_reg    <= '0;
            dismissed_reg  <= '0;
            unread_reg     <= '0;
            pend_reg       <= 1'b0;
        end else begin
            if (cmd.post) begin
                if (used_reg[head_slot_reg]) begin
                    evicted_reg <= evicted_reg + 32'd1;
                end
                if (!used_reg[head_slot_reg] || dism_reg[head_slot_reg]) begin
                    unread_reg <= unread_reg + 1'b1;
                end
                used_reg[head_slot_reg] <= 1'b1;
                disp_reg[head_slot_reg] <= 1'b0;
                dism_reg[head_slot_reg] <= 1'b0;
                next_id_reg    <= next_id_reg + 32'd1;
                write_head_reg <= write_head_reg + 32'd1;
                posted_reg     <= posted_reg + 32'd1;
                if (write_head_reg == '1 || head_slot_reg == LAST_SLOT) begin
                    head_slot_reg <= '0;
                end else begin
                    head_slot_reg <= head_slot_reg + 1'b1;
                end
            end
            if (cmd.scan_read && is_pop) begin
                disp_reg[prev_slot] <= 1'b1;
            end
            if (cmd.dis_idx && !dism_reg[idx_reg]) begin
                dism_reg[idx_reg] <= 1'b1;
                dismissed_reg     <= dismissed_reg + 32'd1;
                unread_reg        <= unread_reg - 1'b1;
            end
            if (cmd.dis_all) begin
                dism_reg      <= dism_reg | used_reg;
                dismissed_reg <= dismissed_reg + 32'(unread_reg);
                unread_reg    <= '0;
            end
            if (cmd.scan_read) begin
                pend_reg <= 1'b1;
            end else if (cmd.load_out) begin
                pend_reg <= 1'b0;
            end
        end
    end

    logic [OUT_BITS-1:0] out_next;
    logic                out_flag_next;

    always_comb begin
        out_next          = '0;
        out_flag_next     = 1'b0;
        out_next[121:116] = 6'(unread_reg);
        out_next[153:122] = posted_reg;
        out_next[185:154] = evicted_reg;
        out_next[217:186] = dismissed_reg;
        case (cmd.out_src)
            SRC_POST: begin
                out_flag_next   = 1'b1;
                out_next[31:0]  = post_id_reg;
                out_next[63:32] = kind_reg;
                out_next[65:64] = urg_clamp;
                out_next[115:68] = time_reg;
            end
            SRC_MEM: begin
                out_flag_next   = 1'b1;
                out_next[31:0]  = mem_q_reg.id;
                out_next[63:32] = mem_q_reg.kind;
                out_next[65:64] = mem_q_reg.urg;
                out_next[66]    = rec_disp_reg;
                out_next[115:68] = mem_q_reg.tstamp;
            end
            default: begin
                out_flag_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid <= 1'b1;
        end else if (m_tready) begin
            m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_last       <= cmd.out_last;
            m_data       <= out_next;
            m_valid_flag <= out_flag_next;
        end
    end

endmodule
`default_nettype wire

[src/notification_ring_table.sv]
// Notification ring table top level: overwriting ring of DEPTH records.
// Post, counts, dismiss-all: a single result item. Read and pop: slots scanned one by one
// (up to DEPTH), one result item per record found, or one item with rec_valid low if none;
// dismiss by id: per slot, memory read, then id compare. One request in flight; a waiting
// result holds.
// Reset (aresetn low, synchronous) clears slot-use flags and counters; id counter to 1.
// Depends on nrt_pkg, nrt_ctrl, nrt_datapath.
`default_nettype none
module notification_ring_table
    import nrt_pkg::*;
#(
    parameter int DEPTH       = 32,
    parameter int MAX_URGENCY = 2
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // req_type[2:0], note_kind[34:3], note_urgency[42:35], post_time[90:43],
    // target_id[122:91], read_limit[128:123], zero fill
    input  wire logic [IN_BITS-1:0]  s_tdata,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // rec_id[31:0], rec_kind[63:32], rec_urgency[65:64], rec_displayed[66],
    // rec_dismissed[67], rec_time[115:68], unread_slots[121:116],
    // posted_total[153:122], evicted_total[185:154], dismissed_total[217:186]
    output logic [OUT_BITS-1:0]      m_tdata,
    // rec_valid[0]
    output logic [0:0]               m_tuser,
    output logic                     m_tlast
);

    nrt_cmd_t cmd;
    nrt_sts_t sts;
    logic     s_accept;

    assign s_tready = cmd.in_ready;
    assign s_accept = s_tvalid && cmd.in_ready;

    nrt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_accept (s_accept),
        .sts      (sts),
        .cmd      (cmd)
    );

    nrt_datapath #(
        .DEPTH       (DEPTH),
        .MAX_URGENCY (MAX_URGENCY)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .s_accept     (s_accept),
        .s_data       (s_tdata),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .m_data       (m_tdata),
        .m_valid_flag (m_tuser[0]),
        .m_last       (m_tlast)
    );

endmodule
`default_nettype wire
